[src/dnsarx_pkg.sv]
package dnsarx_pkg;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_QNAME,
        PH_QLABEL,
        PH_QPTR,
        PH_QFIX,
        PH_ANAME,
        PH_ALABEL,
        PH_APTR,
        PH_RRFIX,
        PH_RDATA,
        PH_DONE,
        PH_REJECT
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_RCODE_ERR = 3'd1,
        ST_NO_ANSWER = 3'd2,
        ST_NO_A      = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    localparam logic [7:0]  PTR_MASK     = 8'hc0;
    localparam logic [7:0]  MAX_LABEL    = 8'd63;
    localparam logic [3:0]  HDR_LAST_IDX = 4'd11;
    localparam logic [3:0]  QFIX_LAST_IDX = 4'd3;
    localparam logic [3:0]  RR_LAST_IDX  = 4'd9;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] CLASS_IN     = 16'd1;
    localparam logic [15:0] A_RDLENGTH   = 16'd4;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } msg_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  server_rcode;
        logic [31:0] host_addr;
        logic [15:0] a_record_count;
    } result_word_t;

endpackage

[src/dns_response_a_record_extractor.sv]
// DNS response A-record extractor.
//
// The msg channel carries a DNS message one byte per word, header first,
// with last_byte set on the final byte. The result channel carries one
// word per message: status, server rcode, the address of the last class-IN
// type-A answer, and the number of such answers seen.
//
// A byte is captured in an input register and parsed from there while
// the output register can advance. The result word is loaded into the
// output register when the final byte is parsed, and result_valid rises
// with it; it is taken while result_stall is low. Throughput is one byte per
// cycle unless a valid result stalls; the parser update is combinational.
// The parser returns to the header phase after each final byte, so
// messages may follow back to back.
//
// Reset clears the parser and both valid flags. While the receiver stalls a
// valid result, the input register holds its byte and msg_stall rises
// once that register is occupied; nothing is dropped.
module dns_response_a_record_extractor
    import dnsarx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_word_t    msg,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    logic         in_valid_reg;
    msg_word_t    in_data_reg;
    logic         advance;
    logic         process;

    phase_t       phase_reg, phase_next;
    logic [3:0]   idx_reg, idx_next;
    logic [15:0]  skip_reg, skip_next;
    logic [15:0]  answers_reg, answers_next;
    logic [15:0]  flags_reg, flags_next;
    logic [15:0]  rtype_reg, rtype_next;
    logic [15:0]  rclass_reg, rclass_next;
    logic [31:0]  shift_reg, shift_next;
    logic [31:0]  kept_reg, kept_next;
    logic [15:0]  count_reg, count_next;
    logic         malformed_reg, malformed_next;

    logic         result_valid_reg;
    result_word_t result_reg, result_next;

    logic [7:0]   b;
    logic         is_in_a;
    logic         end_rec;
    logic [15:0]  answers_dec;
    logic [15:0]  skip_dec;

    assign advance   = !result_valid_reg || !result_stall;
    assign process   = in_valid_reg && advance;
    assign msg_stall = in_valid_reg && !advance;

    assign b       = in_data_reg.msg_byte;
    assign is_in_a = (rtype_reg == TYPE_A) && (rclass_reg == CLASS_IN);
    assign skip_dec = skip_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        skip_next      = skip_reg;
        answers_next   = answers_reg;
        flags_next     = flags_reg;
        rtype_next     = rtype_reg;
        rclass_next    = rclass_reg;
        shift_next     = shift_reg;
        kept_next      = kept_reg;
        count_next     = count_reg;
        malformed_next = malformed_reg;
        end_rec        = 1'b0;
        answers_dec    = answers_reg - 16'd1;

        unique case (phase_reg) inside
            PH_HDR:
            begin
                case (idx_reg)
                    4'd2:    flags_next   = {b, 8'h00};
                    4'd3:    flags_next   = {flags_reg[15:8], b};
                    4'd6:    answers_next = {b, 8'h00};
                    4'd7:    answers_next = {answers_reg[15:8], b};
                    default: ;
                endcase
                if (idx_reg >= HDR_LAST_IDX)
                begin
                    idx_next = 4'd0;
                    if (flags_reg[3:0] != 4'd0 || answers_reg == 16'd0 || !flags_reg[15])
                        phase_next = PH_REJECT;
                    else
                        phase_next = PH_QNAME;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_QNAME, PH_ANAME:
            begin
                if (b == 8'd0)
                begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QFIX : PH_RRFIX;
                    idx_next   = 4'd0;
                end
                else if ((b & PTR_MASK) == PTR_MASK)
                begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                end
                else if (b > MAX_LABEL)
                begin
                    malformed_next = 1'b1;
                    phase_next     = PH_DONE;
                end
                else
                begin
                    skip_next  = {8'h00, b};
                    phase_next = (phase_reg == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QLABEL, PH_ALABEL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = (phase_reg == PH_QLABEL) ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR:
            begin
                phase_next = PH_QFIX;
                idx_next   = 4'd0;
            end
            PH_APTR:
            begin
                phase_next = PH_RRFIX;
                idx_next   = 4'd0;
            end
            PH_QFIX:
            begin
                if (idx_reg >= QFIX_LAST_IDX)
                begin
                    phase_next = PH_ANAME;
                    idx_next   = 4'd0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_RRFIX:
            begin
                case (idx_reg)
                    4'd0:    rtype_next  = {b, 8'h00};
                    4'd1:    rtype_next  = {rtype_reg[15:8], b};
                    4'd2:    rclass_next = {b, 8'h00};
                    4'd3:    rclass_next = {rclass_reg[15:8], b};
                    4'd8:    skip_next   = {b, 8'h00};
                    4'd9:    skip_next   = {skip_reg[15:8], b};
                    default: ;
                endcase
                if (idx_reg >= RR_LAST_IDX)
                begin
                    idx_next = 4'd0;
                    if (is_in_a && skip_next != A_RDLENGTH)
                    begin
                        malformed_next = 1'b1;
                        phase_next     = PH_DONE;
                    end
                    else if (skip_next == 16'd0)
                        end_rec = 1'b1;
                    else
                        phase_next = PH_RDATA;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_RDATA:
            begin
                shift_next = {shift_reg[23:0], b};
                skip_next  = skip_dec;
                if (skip_dec == 16'd0)
                    end_rec = 1'b1;
            end
            default: ;
        endcase

        // Close one answer record: keep an IN A address and count down answers.
        if (end_rec)
        begin
            if (is_in_a)
            begin
                kept_next = shift_next;
                if (count_reg < COUNT_MAX)
                    count_next = count_reg + 16'd1;
            end
            answers_next = answers_dec;
            phase_next   = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
            idx_next     = 4'd0;
        end
    end

    always_comb
    begin
        result_next.server_rcode   = flags_next[3:0];
        result_next.host_addr      = kept_next;
        result_next.a_record_count = count_next;
        if (phase_next == PH_HDR)
        begin
            result_next.status       = ST_MALFORMED;
            result_next.server_rcode = 4'd0;
        end
        else if (phase_next == PH_REJECT)
            result_next.status = (flags_next[3:0] != 4'd0) ? ST_RCODE_ERR : ST_NO_ANSWER;
        else if (malformed_next || phase_next != PH_DONE)
            result_next.status = ST_MALFORMED;
        else if (count_next == 16'd0)
            result_next.status = ST_NO_A;
        else
            result_next.status = ST_FOUND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_HDR;
            idx_reg          <= 4'd0;
            skip_reg         <= 16'd0;
            answers_reg      <= 16'd0;
            flags_reg        <= 16'd0;
            rtype_reg        <= 16'd0;
            rclass_reg       <= 16'd0;
            shift_reg        <= 32'd0;
            kept_reg         <= 32'd0;
            count_reg        <= 16'd0;
            malformed_reg    <= 1'b0;
        end
        else
        begin
            if (!msg_stall)
                in_valid_reg <= msg_valid;

            if (advance)
                result_valid_reg <= process && in_data_reg.last_byte;

            if (process)
            begin
                if (in_data_reg.last_byte)
                begin
                    phase_reg     <= PH_HDR;
                    idx_reg       <= 4'd0;
                    skip_reg      <= 16'd0;
                    answers_reg   <= 16'd0;
                    flags_reg     <= 16'd0;
                    rtype_reg     <= 16'd0;
                    rclass_reg    <= 16'd0;
                    shift_reg     <= 32'd0;
                    kept_reg      <= 32'd0;
                    count_reg     <= 16'd0;
                    malformed_reg <= 1'b0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    idx_reg       <= idx_next;
                    skip_reg      <= skip_next;
                    answers_reg   <= answers_next;
                    flags_reg     <= flags_next;
                    rtype_reg     <= rtype_next;
                    rclass_reg    <= rclass_next;
                    shift_reg     <= shift_next;
                    kept_reg      <= kept_next;
                    count_reg     <= count_next;
                    malformed_reg <= malformed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!msg_stall && msg_valid)
            in_data_reg <= msg;
        if (process && in_data_reg.last_byte)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_data_reg.last_byte) |=> result_valid)
        else $error("final byte did not produce a result word");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_data_reg.last_byte) |=>
            (phase_reg == PH_HDR && idx_reg == 4'd0 && count_reg == 16'd0))
        else $error("parser did not restart after final byte");

    a_malformed_done: assert property (@(posedge clk) disable iff (!rst_n)
        malformed_reg |-> (phase_reg == PH_DONE))
        else $error("malformed flag set outside done phase");

    a_found_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_FOUND) |-> (result.a_record_count != 16'd0))
        else $error("found status with zero A count");

    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR) |-> (idx_reg <= HDR_LAST_IDX))
        else $error("header byte index out of range");

endmodule

[test/dnsarx_checker.sv]
module dnsarx_checker
    import dnsarx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    input  logic         msg_stall,
    input  msg_word_t    msg,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_word_t result,
    output int           fail_count,
    output int           expected_left,
    output int           results_seen,
    output int           found_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state as the block should hold it.
    phase_t      phase;
    logic [3:0]  idx;
    logic [15:0] skip_left;
    logic [15:0] answers;
    logic [15:0] flags;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [31:0] addr_shift;
    logic [31:0] kept_ip;
    logic [15:0] a_count;
    logic        bad;

    result_word_t expected_reports[$];
    int n_fail;
    int n_results;
    int n_found;

    task automatic clear_parser();
        phase = PH_HDR;
        idx = '0;
        skip_left = '0;
        answers = '0;
        flags = '0;
        rtype = '0;
        rclass = '0;
        addr_shift = '0;
        kept_ip = '0;
        a_count = '0;
        bad = 1'b0;
    endtask

    task automatic mark_bad();
        bad = 1'b1;
        phase = PH_DONE;
    endtask

    task automatic take_name_byte(input logic [7:0] b, input phase_t label_ph,
                                  input phase_t ptr_ph, input phase_t end_ph);
        if (b == 8'd0) begin
            phase = end_ph;
            idx = '0;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
            phase = ptr_ph;
        end else if (b > MAX_LABEL) begin
            mark_bad();
        end else begin
            skip_left = {8'd0, b};
            phase = label_ph;
        end
    endtask

    function automatic logic is_in_a();
        return rtype == TYPE_A && rclass == CLASS_IN;
    endfunction

    task automatic close_record();
        if (is_in_a()) begin
            kept_ip = addr_shift;
            if (a_count != COUNT_MAX)
                a_count = a_count + 16'd1;
        end
        answers = answers - 16'd1;
        phase = (answers == 16'd0) ? PH_DONE : PH_ANAME;
        idx = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            PH_HDR:
            begin
                if (idx == 4'd2) flags = {b, 8'h00};
                else if (idx == 4'd3) flags = flags | {8'h00, b};
                else if (idx == 4'd6) answers = {b, 8'h00};
                else if (idx == 4'd7) answers = answers | {8'h00, b};
                if (idx >= HDR_LAST_IDX) begin
                    idx = '0;
                    if (flags[3:0] != 4'd0 || answers == 16'd0 || !flags[15])
                        phase = PH_REJECT;
                    else
                        phase = PH_QNAME;
                end else begin
                    idx = idx + 4'd1;
                end
            end
            PH_QNAME: take_name_byte(b, PH_QLABEL, PH_QPTR, PH_QFIX);
            PH_ANAME: take_name_byte(b, PH_ALABEL, PH_APTR, PH_RRFIX);
            PH_QLABEL, PH_ALABEL:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    phase = (phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR:
            begin
                phase = PH_QFIX;
                idx = '0;
            end
            PH_APTR:
            begin
                phase = PH_RRFIX;
                idx = '0;
            end
            PH_QFIX:
            begin
                if (idx >= QFIX_LAST_IDX) begin
                    phase = PH_ANAME;
                    idx = '0;
                end else begin
                    idx = idx + 4'd1;
                end
            end
            PH_RRFIX:
            begin
                if (idx == 4'd0) rtype = {b, 8'h00};
                else if (idx == 4'd1) rtype = rtype | {8'h00, b};
                else if (idx == 4'd2) rclass = {b, 8'h00};
                else if (idx == 4'd3) rclass = rclass | {8'h00, b};
                else if (idx == 4'd8) skip_left = {b, 8'h00};
                else if (idx == 4'd9) skip_left = skip_left | {8'h00, b};
                if (idx >= RR_LAST_IDX) begin
                    idx = '0;
                    if (is_in_a() && skip_left != A_RDLENGTH)
                        mark_bad();
                    else if (skip_left == 16'd0)
                        close_record();
                    else
                        phase = PH_RDATA;
                end else begin
                    idx = idx + 4'd1;
                end
            end
            PH_RDATA:
            begin
                addr_shift = {addr_shift[23:0], b};
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    close_record();
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic result_word_t message_report();
        result_word_t r;
        status_t      st;
        r.server_rcode = flags[3:0];
        if (phase == PH_HDR) begin
            st = ST_MALFORMED;
            r.server_rcode = 4'd0;
        end else if (phase == PH_REJECT) begin
            st = (flags[3:0] != 4'd0) ? ST_RCODE_ERR : ST_NO_ANSWER;
        end else if (bad || phase != PH_DONE) begin
            st = ST_MALFORMED;
        end else if (a_count == 16'd0) begin
            st = ST_NO_A;
        end else begin
            st = ST_FOUND;
        end
        r.status = st;
        r.host_addr = kept_ip;
        r.a_record_count = a_count;
        return r;
    endfunction

    task automatic compare_report(input result_word_t got);
        result_word_t want;
        if (expected_reports.size() == 0) begin
            $error("result word with no message pending: status %0d ip %0h count %0d",
                   got.status, got.host_addr, got.a_record_count);
            n_fail++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
        end
        if (got.server_rcode !== want.server_rcode) begin
            $error("server_rcode: expected %0d, got %0d", want.server_rcode, got.server_rcode);
            n_fail++;
        end
        if (got.host_addr !== want.host_addr) begin
            $error("host_addr: expected %h, got %h", want.host_addr, got.host_addr);
            n_fail++;
        end
        if (got.a_record_count !== want.a_record_count) begin
            $error("a_record_count: expected %0d, got %0d",
                   want.a_record_count, got.a_record_count);
            n_fail++;
        end
        n_results++;
        if (want.status == ST_FOUND)
            n_found++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_parser();
            expected_reports.delete();
            n_fail = 0;
            n_results = 0;
            n_found = 0;
        end else begin
            if (result_valid && !result_stall)
                compare_report(result);
            if (msg_valid && !msg_stall) begin
                parse_byte(msg.msg_byte);
                if (msg.last_byte) begin
                    expected_reports.push_back(message_report());
                    clear_parser();
                end
            end
        end
        fail_count <= n_fail;
        expected_left <= expected_reports.size();
        results_seen <= n_results;
        found_seen <= n_found;
    end

endmodule

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dnsarx_pkg::*;

    localparam logic [15:0] TYPE_CNAME  = 16'd5;
    localparam logic [15:0] TYPE_AAAA   = 16'd28;
    localparam int          QUIET_LIMIT = 4000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_word_t    msg = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    int fail_count;
    int expected_left;
    int results_seen;
    int found_seen;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit snd_steady = 1'b0;
    bit rcv_steady = 1'b0;
    int bytes_sent = 0;
    int msgs_sent = 0;
    int quiet_cycles = 0;
    logic [7:0] pkt[$];

    dns_response_a_record_extractor DUT (.*);
    dnsarx_checker CHECK (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver stalls at the current rate, with occasional stretches of none.
    always @(posedge clk) begin
        if ($urandom_range(255) == 0)
            rcv_steady = !rcv_steady;
        result_stall <= !rcv_steady && ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (msg_valid && !msg_stall) || (result_valid && !result_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic fin);
        msg_word_t w;
        w.msg_byte = b;
        w.last_byte = fin;
        if (!snd_steady) begin
            while ($urandom_range(99) < snd_idle_pct) begin
                msg_valid <= 1'b0;
                @(posedge clk);
            end
        end
        msg_valid <= 1'b1;
        msg <= w;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        snd_steady = ($urandom_range(3) == 0);
        foreach (pkt[i])
            send_word(pkt[i], i == pkt.size() - 1);
        pkt.delete();
        msgs_sent++;
    endtask

    // Hold the sender off until every pending report has come back.
    task automatic wait_drained();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    task automatic put_random(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [15:0] fl, input logic [15:0] an);
        put_random(2);
        put16(fl);
        put16(16'd1);
        put16(an);
        put_random(4);
    endtask

    // Type, class, TTL, rdlength and rdata of one record; the name goes first.
    task automatic put_record_body(input logic [15:0] ty, input logic [15:0] cl,
                                   input logic [15:0] len);
        put16(ty);
        put16(cl);
        put_random(4);
        put16(len);
        put_random(len);
    endtask

    task automatic put_name();
        int labels;
        int len;
        int r;
        labels = $urandom_range(3);
        repeat (labels) begin
            r = $urandom_range(99);
            if (r < 3) begin
                pkt.push_back(8'($urandom_range(64, 191)));
                return;
            end
            len = (r < 8) ? 63 : $urandom_range(1, 8);
            pkt.push_back(8'(len));
            put_random(len);
        end
        if ($urandom_range(1)) begin
            pkt.push_back(8'hc0 | 8'($urandom_range(63)));
            pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(8'h00);
        end
    endtask

    task automatic put_random_record();
        int          r;
        logic [15:0] ty;
        logic [15:0] cl;
        logic [15:0] len;
        r = $urandom_range(99);
        ty = (r < 55) ? TYPE_A : (r < 70) ? TYPE_CNAME : (r < 80) ? TYPE_AAAA : 16'($urandom);
        cl = ($urandom_range(99) < 85) ? CLASS_IN : 16'($urandom);
        if (ty == TYPE_A && cl == CLASS_IN)
            len = ($urandom_range(99) < 92) ? A_RDLENGTH : 16'($urandom_range(8));
        else if (ty == TYPE_AAAA)
            len = 16'd16;
        else
            len = 16'($urandom_range(8));
        put_name();
        put_record_body(ty, cl, len);
    endtask

    // Mostly well-formed responses with random content; some broken or noise.
    task automatic build_random_msg();
        int          n_ans;
        int          n_hdr;
        int          r;
        logic [15:0] fl;
        r = $urandom_range(99);
        if (r < 5) begin
            put_random($urandom_range(1, 40));
            return;
        end
        n_ans = $urandom_range(1, 4);
        n_hdr = n_ans;
        fl = 16'($urandom);
        fl[15] = 1'b1;
        fl[3:0] = 4'd0;
        if (r < 9)
            fl[3:0] = 4'($urandom_range(1, 15));
        else if (r < 12)
            fl[15] = 1'b0;
        else if (r < 14)
            n_hdr = 0;
        else if (r < 24)
            n_hdr = n_ans + 1;
        else if (r < 32)
            n_hdr = n_ans - 1;
        else if (r < 35)
            n_hdr = $urandom_range(65535);
        put_header(fl, 16'(n_hdr));
        put_name();
        put_random(4);
        repeat (n_ans) put_random_record();
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, pkt.size() - 1)) pkt.pop_back();
        else if ($urandom_range(99) < 10)
            put_random($urandom_range(1, 4));
    endtask

    task automatic run_directed();
        // Header cut short after one byte.
        pkt.push_back(8'hff);
        send_packet();
        // Root question and one A answer through a compression pointer.
        put_header(16'h8180, 16'd1);
        pkt.push_back(8'h00);
        put16(TYPE_A);
        put16(CLASS_IN);
        put16(16'hc00c);
        put_record_body(TYPE_A, CLASS_IN, A_RDLENGTH);
        send_packet();
        // Server error code; the rest is ignored.
        put_header(16'h818f, 16'd1);
        put16(16'hffff);
        send_packet();
        // Response bit clear.
        put_header(16'h0100, 16'd1);
        send_packet();
        // No answers.
        put_header(16'h8180, 16'd0);
        send_packet();
        // Longest legal label, a labeled answer name, CNAME then A, trailing bytes.
        put_header(16'h8580, 16'd2);
        pkt.push_back(8'd63);
        put_random(63);
        pkt.push_back(8'h00);
        put_random(4);
        pkt.push_back(8'd3);
        put_random(3);
        pkt.push_back(8'h00);
        put_record_body(TYPE_CNAME, CLASS_IN, 16'd2);
        put16(16'hc00c);
        put_record_body(TYPE_A, CLASS_IN, A_RDLENGTH);
        put_random(2);
        send_packet();
        // Smallest oversized label in the question.
        put_header(16'h8180, 16'd1);
        pkt.push_back(8'd64);
        put16(16'h0000);
        send_packet();
        // Largest oversized label after an A answer was kept.
        put_header(16'h8180, 16'd2);
        pkt.push_back(8'h00);
        put_random(4);
        put16(16'hc00c);
        put_record_body(TYPE_A, CLASS_IN, A_RDLENGTH);
        pkt.push_back(8'd191);
        pkt.push_back(8'h00);
        send_packet();
        // IN A answer with the wrong rdata length.
        put_header(16'h8180, 16'd1);
        pkt.push_back(8'h00);
        put_random(4);
        put16(16'hc00c);
        put_record_body(TYPE_A, CLASS_IN, 16'd5);
        send_packet();
        // Answer count far beyond what arrives.
        put_header(16'h8180, 16'hffff);
        pkt.push_back(8'h00);
        put_random(4);
        put16(16'hc00c);
        put_record_body(TYPE_A, CLASS_IN, A_RDLENGTH);
        send_packet();
        // Pointer byte with all bits set; type A in another class gives no A record.
        put_header(16'h8180, 16'd1);
        put16(16'hffff);
        put_random(4);
        put16(16'hff00);
        put_record_body(TYPE_A, 16'd3, 16'd0);
        send_packet();
    endtask

    initial begin
        int phase_no;
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        snd_idle_pct = 24;
        rcv_idle_pct = 75;
        run_directed();
        for (phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0:
                begin
                    snd_idle_pct = 24;
                    rcv_idle_pct = 75;
                end
                1:
                begin
                    snd_idle_pct = 75;
                    rcv_idle_pct = 24;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            target = bytes_sent + 450;
            while (bytes_sent < target) begin
                build_random_msg();
                send_packet();
                if ($urandom_range(19) == 0)
                    wait_drained();
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes in %0d messages under three stall patterns.",
                 bytes_sent, msgs_sent);
        $display("Compared %0d reports, %0d of them with an address found.",
                 results_seen, found_seen);
        if (fail_count == 0 && expected_left == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (expected_left != 0)
                $error("%0d expected reports never arrived", expected_left);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/dnsarx_pkg.sv
src/dns_response_a_record_extractor.sv
test/dnsarx_checker.sv
test/testbench.sv
